FILE: hw/rtl/i2crtm_pkg.sv
// Shared types, codes and helpers of the I2C register transaction master.
package i2crtm_pkg;

    // Request codes carried in the operation field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] ACK_POLL_RESET = 8'd10;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

    // Index of the last byte sent per request kind
    localparam logic [2:0] LAST_BYTE_WRITE = 3'd3;
    localparam logic [2:0] LAST_BYTE_OTHER = 3'd1;

    // Byte index after which the master ACKs instead of NACKs a read byte
    localparam logic [2:0] FIRST_READ_BYTE  = 3'd1;
    localparam logic [2:0] SECOND_READ_BYTE = 3'd2;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_TX_LOW    = 4'd1,
        PH_TX_HIGH   = 4'd2,
        PH_ACK_LOW   = 4'd3,
        PH_ACK_HIGH  = 4'd4,
        PH_RX_LOW    = 4'd5,
        PH_RX_HIGH   = 4'd6,
        PH_MACK_LOW  = 4'd7,
        PH_MACK_HIGH = 4'd8,
        PH_STOP_LOW  = 4'd9,
        PH_STOP_HIGH = 4'd10,
        PH_STOP_END  = 4'd11
    } phase_t;

    // One bus tick as it enters the block
    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  device_address;
        logic [7:0]  register_pointer;
        logic [15:0] write_value;
        logic        sda_sample;
    } item_t;

    // Line levels and status produced for one tick
    typedef struct packed {
        logic        scl_level;
        logic        sda_pull_low;
        logic        busy_res;
        logic        done_res;
        logic        ack_missing;
        logic [15:0] read_data;
    } result_t;

    // Pick the byte to shift out at a given position of the transaction
    function automatic logic [7:0] tx_byte(
        input logic [2:0]  idx,
        input logic [7:0]  addr,
        input logic [7:0]  ptr,
        input logic [15:0] value
    );
        logic [7:0] b;
        case (idx)
            3'd0:    b = addr;
            3'd1:    b = ptr;
            3'd2:    b = value[15:8];
            3'd3:    b = value[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/i2crtm_input_stage.sv
// Input register of the I2C master: holds one tick until the sequencer takes it.
module i2crtm_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  i2crtm_pkg::item_t   item_in,
    input  logic                advance,
    output logic                stage_valid,
    output i2crtm_pkg::item_t   stage_item
);

    logic              valid_reg;
    i2crtm_pkg::item_t item_reg;

    // Hold the word while the sequencer cannot take it
    assign item_stall  = valid_reg && !advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item_in;
        end
    end

endmodule

FILE: hw/rtl/i2crtm_sequencer.sv
// Bus phase sequencer of the I2C master: one phase step per accepted tick.
module i2crtm_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  i2crtm_pkg::item_t    item,
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_data,
    output i2crtm_pkg::result_t  res
);

    i2crtm_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] received_word_reg, received_word_next;
    logic [7:0]  ack_polls_reg, ack_polls_next;
    logic [1:0]  held_op_reg, held_op_next;
    logic [7:0]  held_addr_reg, held_addr_next;
    logic [7:0]  held_ptr_reg, held_ptr_next;
    logic [15:0] held_value_reg, held_value_next;
    logic [7:0]  ack_poll_limit_reg;

    logic [3:0]  bit_count_inc;
    logic [2:0]  byte_index_inc;
    logic [2:0]  last_index;

    assign bit_count_inc  = bit_count_reg + 4'd1;
    assign byte_index_inc = byte_index_reg + 3'd1;
    assign last_index     = (held_op_reg == i2crtm_pkg::OP_WRITE) ?
                            i2crtm_pkg::LAST_BYTE_WRITE : i2crtm_pkg::LAST_BYTE_OTHER;

    // Next state
    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        byte_index_next    = byte_index_reg;
        shift_byte_next    = shift_byte_reg;
        received_word_next = received_word_reg;
        ack_polls_next     = ack_polls_reg;
        held_op_next       = held_op_reg;
        held_addr_next     = held_addr_reg;
        held_ptr_next      = held_ptr_reg;
        held_value_next    = held_value_reg;
        unique case (phase_reg)
            i2crtm_pkg::PH_TX_LOW:
            begin
                phase_next = i2crtm_pkg::PH_TX_HIGH;
            end
            i2crtm_pkg::PH_TX_HIGH:
            begin
                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                if (bit_count_inc >= i2crtm_pkg::BITS_PER_BYTE)
                begin
                    bit_count_next = 4'd0;
                    ack_polls_next = 8'd0;
                    phase_next     = i2crtm_pkg::PH_ACK_LOW;
                end
                else
                begin
                    bit_count_next = bit_count_inc;
                    phase_next     = i2crtm_pkg::PH_TX_LOW;
                end
            end
            i2crtm_pkg::PH_ACK_LOW:
            begin
                phase_next = i2crtm_pkg::PH_ACK_HIGH;
            end
            i2crtm_pkg::PH_ACK_HIGH:
            begin
                if (!item.sda_sample)
                begin
                    byte_index_next = byte_index_inc;
                    if (held_op_reg == i2crtm_pkg::OP_READ)
                    begin
                        bit_count_next = 4'd0;
                        phase_next     = i2crtm_pkg::PH_RX_LOW;
                    end
                    else if (byte_index_inc <= last_index)
                    begin
                        shift_byte_next = i2crtm_pkg::tx_byte(byte_index_inc, held_addr_reg,
                                                              held_ptr_reg, held_value_reg);
                        bit_count_next  = 4'd0;
                        phase_next      = i2crtm_pkg::PH_TX_LOW;
                    end
                    else
                    begin
                        bit_count_next = 4'd0;
                        phase_next     = i2crtm_pkg::PH_STOP_LOW;
                    end
                end
                else if (ack_polls_reg >= ack_poll_limit_reg)
                begin
                    // no ACK in time: the error flag rides in bit_count through STOP
                    bit_count_next = 4'd1;
                    phase_next     = i2crtm_pkg::PH_STOP_LOW;
                end
                else
                begin
                    ack_polls_next = ack_polls_reg + 8'd1;
                end
            end
            i2crtm_pkg::PH_RX_LOW:
            begin
                phase_next = i2crtm_pkg::PH_RX_HIGH;
            end
            i2crtm_pkg::PH_RX_HIGH:
            begin
                received_word_next = {received_word_reg[14:0], item.sda_sample};
                if (bit_count_inc >= i2crtm_pkg::BITS_PER_BYTE)
                begin
                    bit_count_next = 4'd0;
                    phase_next     = i2crtm_pkg::PH_MACK_LOW;
                end
                else
                begin
                    bit_count_next = bit_count_inc;
                    phase_next     = i2crtm_pkg::PH_RX_LOW;
                end
            end
            i2crtm_pkg::PH_MACK_LOW:
            begin
                phase_next = i2crtm_pkg::PH_MACK_HIGH;
            end
            i2crtm_pkg::PH_MACK_HIGH:
            begin
                bit_count_next = 4'd0;
                if (byte_index_reg == i2crtm_pkg::FIRST_READ_BYTE)
                begin
                    byte_index_next = i2crtm_pkg::SECOND_READ_BYTE;
                    phase_next      = i2crtm_pkg::PH_RX_LOW;
                end
                else
                begin
                    phase_next = i2crtm_pkg::PH_STOP_LOW;
                end
            end
            i2crtm_pkg::PH_STOP_LOW:
            begin
                phase_next = i2crtm_pkg::PH_STOP_HIGH;
            end
            i2crtm_pkg::PH_STOP_HIGH:
            begin
                phase_next = i2crtm_pkg::PH_STOP_END;
            end
            i2crtm_pkg::PH_STOP_END:
            begin
                bit_count_next = 4'd0;
                phase_next     = i2crtm_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = i2crtm_pkg::PH_IDLE;
                if (item.operation != i2crtm_pkg::OP_TICK)
                begin
                    held_op_next    = item.operation;
                    held_addr_next  = item.device_address;
                    held_ptr_next   = item.register_pointer;
                    held_value_next = item.write_value;
                    byte_index_next = 3'd0;
                    bit_count_next  = 4'd0;
                    ack_polls_next  = 8'd0;
                    shift_byte_next = item.device_address;
                    if (item.operation == i2crtm_pkg::OP_READ)
                    begin
                        received_word_next = 16'h0000;
                    end
                    phase_next = i2crtm_pkg::PH_TX_LOW;
                end
            end
        endcase
    end

    // Line levels and status for this tick
    always_comb
    begin
        res.scl_level    = 1'b1;
        res.sda_pull_low = 1'b0;
        res.busy_res     = 1'b1;
        res.done_res     = 1'b0;
        res.ack_missing  = 1'b0;
        res.read_data    = received_word_next;
        unique case (phase_reg) inside
            i2crtm_pkg::PH_TX_LOW:
            begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = !shift_byte_reg[7];
            end
            i2crtm_pkg::PH_TX_HIGH:
            begin
                res.sda_pull_low = !shift_byte_reg[7];
            end
            i2crtm_pkg::PH_ACK_LOW,
            i2crtm_pkg::PH_RX_LOW:
            begin
                res.scl_level = 1'b0;
            end
            i2crtm_pkg::PH_ACK_HIGH,
            i2crtm_pkg::PH_RX_HIGH:
            begin
                res.scl_level = 1'b1;
            end
            i2crtm_pkg::PH_MACK_LOW:
            begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = (byte_index_reg == i2crtm_pkg::FIRST_READ_BYTE);
            end
            i2crtm_pkg::PH_MACK_HIGH:
            begin
                res.sda_pull_low = (byte_index_reg == i2crtm_pkg::FIRST_READ_BYTE);
            end
            i2crtm_pkg::PH_STOP_LOW:
            begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = 1'b1;
            end
            i2crtm_pkg::PH_STOP_HIGH:
            begin
                res.sda_pull_low = 1'b1;
            end
            i2crtm_pkg::PH_STOP_END:
            begin
                res.done_res    = 1'b1;
                res.ack_missing = bit_count_reg[0];
            end
            default:
            begin
                if (item.operation != i2crtm_pkg::OP_TICK)
                begin
                    res.sda_pull_low = 1'b1;
                end
                else
                begin
                    res.busy_res = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= i2crtm_pkg::PH_IDLE;
            bit_count_reg     <= 4'd0;
            byte_index_reg    <= 3'd0;
            shift_byte_reg    <= 8'h00;
            received_word_reg <= 16'h0000;
            ack_polls_reg     <= 8'h00;
            held_op_reg       <= 2'd0;
            held_addr_reg     <= 8'h00;
            held_ptr_reg      <= 8'h00;
            held_value_reg    <= 16'h0000;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            byte_index_reg    <= byte_index_next;
            shift_byte_reg    <= shift_byte_next;
            received_word_reg <= received_word_next;
            ack_polls_reg     <= ack_polls_next;
            held_op_reg       <= held_op_next;
            held_addr_reg     <= held_addr_next;
            held_ptr_reg      <= held_ptr_next;
            held_value_reg    <= held_value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_poll_limit_reg <= i2crtm_pkg::ACK_POLL_RESET;
        end
        else if (cfg_write)
        begin
            ack_poll_limit_reg <= cfg_data;
        end
    end

`ifndef ASSERT_OFF
    // A STOP that finishes always drops the sequencer back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == i2crtm_pkg::PH_STOP_END) |=> (phase_reg == i2crtm_pkg::PH_IDLE))
        else $error("sequencer did not return to idle after STOP");

    // A request taken while idle starts the first data bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == i2crtm_pkg::PH_IDLE &&
         item.operation != i2crtm_pkg::OP_TICK) |=> (phase_reg == i2crtm_pkg::PH_TX_LOW))
        else $error("request in idle did not start a transfer");

    // The bit counter never reaches a full byte between steps
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg < i2crtm_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");

    // Without an advance the sequencer state holds
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(received_word_reg))
        else $error("sequencer state moved without an accepted tick");
`endif

endmodule

FILE: hw/rtl/i2crtm_output_stage.sv
// Result register of the I2C master: holds one tick's line levels until taken.
module i2crtm_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  i2crtm_pkg::result_t  res_in,
    output logic                 stage_free,
    output logic                 result_valid,
    input  logic                 result_stall,
    output i2crtm_pkg::result_t  res_out
);

    logic                valid_reg;
    i2crtm_pkg::result_t res_reg;

    // Free when empty or when the held word leaves this cycle
    assign stage_free   = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign res_out      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_free)
        begin
            valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_in;
        end
    end

endmodule

FILE: hw/rtl/i2c_register_transaction_master_core.sv
// Top level of the I2C register transaction master.
// Each accepted input word is one bus half-period tick: it carries the sampled
// SDA level and, while the block is idle, an optional request (write register,
// set pointer, or read two bytes). The block answers every tick with exactly
// one result word giving the SCL level and SDA pull-down to drive, plus busy,
// a one-tick done pulse, the missing-ACK flag and the last read data. A tick
// passes through an input register, one step of the phase sequencer, and a
// result register, so a new tick is taken every cycle while the result side is
// not stalled; its result word is presented once the sequencer step has loaded
// it into the result register. A stalled result holds the result register,
// which holds the input register and raises item_stall in the same cycle. The
// sequencer's state registers (phase, counters, shift and hold registers) form
// its feedback loop.
// The ACK poll limit register may be written through the cfg port whenever the
// block is idle; cfg_ready is always high.
module i2c_register_transaction_master_core (
    input  logic        clk,
    input  logic        rst_n,

    // tick input channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  device_address,
    input  logic [7:0]  register_pointer,
    input  logic [15:0] write_value,
    input  logic        sda_sample,

    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic        scl_level,
    output logic        sda_pull_low,
    output logic        busy_res,
    output logic        done_res,
    output logic        ack_missing,
    output logic [15:0] read_data,

    // configuration: ack_poll_limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    i2crtm_pkg::item_t   item_in;
    i2crtm_pkg::item_t   stage_item;
    i2crtm_pkg::result_t step_res;
    i2crtm_pkg::result_t res_out;
    logic                stage_valid;
    logic                stage_free;
    logic                advance;

    // Pack the tick fields into one word
    assign item_in.operation        = operation;
    assign item_in.device_address   = device_address;
    assign item_in.register_pointer = register_pointer;
    assign item_in.write_value      = write_value;
    assign item_in.sda_sample       = sda_sample;

    // Advance the sequencer whenever a tick waits and the result register has room
    assign advance   = stage_valid && stage_free;
    assign cfg_ready = 1'b1;

    i2crtm_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_in     (item_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    i2crtm_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (stage_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res       (step_res)
    );

    i2crtm_output_stage u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .res_in       (step_res),
        .stage_free   (stage_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .res_out      (res_out)
    );

    // Unpack the result word onto the field ports
    assign scl_level    = res_out.scl_level;
    assign sda_pull_low = res_out.sda_pull_low;
    assign busy_res     = res_out.busy_res;
    assign done_res     = res_out.done_res;
    assign ack_missing  = res_out.ack_missing;
    assign read_data    = res_out.read_data;

endmodule

FILE: tb/tb_i2c_register_transaction_master_core.sv
// Self-checking testbench for the I2C register transaction master core.
`timescale 1ns / 100ps

module tb_i2c_register_transaction_master_core;

    // Give up long after the slowest legal run would have ended
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_GAP      = 17;
    localparam int RANDOM_TICKS = 100;
    localparam int NONE         = -1;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        item_valid;
    logic        item_stall;
    logic [1:0]  operation;
    logic [7:0]  device_address;
    logic [7:0]  register_pointer;
    logic [15:0] write_value;
    logic        sda_sample;

    logic        result_valid;
    logic        result_stall;
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        ack_missing;
    logic [15:0] read_data;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    i2c_register_transaction_master_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .operation        (operation),
        .device_address   (device_address),
        .register_pointer (register_pointer),
        .write_value      (write_value),
        .sda_sample       (sda_sample),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .scl_level        (scl_level),
        .sda_pull_low     (sda_pull_low),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .ack_missing      (ack_missing),
        .read_data        (read_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus sequencer prediction. The state below always reflects every tick
    // word accepted so far, so the sender can also use it to play the slave:
    // it looks at the predicted phase to decide what SDA level to present.
    // ------------------------------------------------------------------
    i2crtm_pkg::phase_t ph   = i2crtm_pkg::PH_IDLE;
    logic [3:0]  bitcnt      = '0;   // also carries the error flag during STOP
    logic [2:0]  byte_idx    = '0;
    logic [7:0]  shreg       = '0;
    logic [15:0] rx_word     = '0;
    logic [7:0]  polls       = '0;
    logic [1:0]  h_op        = i2crtm_pkg::OP_TICK;
    logic [7:0]  h_addr      = '0;
    logic [7:0]  h_ptr       = '0;
    logic [15:0] h_val       = '0;
    logic [7:0]  poll_limit  = i2crtm_pkg::ACK_POLL_RESET;

    // Byte shifted out at a given position of the held request
    function automatic logic [7:0] request_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = h_addr;
            3'd1:    b = h_ptr;
            3'd2:    b = h_val[15:8];
            3'd3:    b = h_val[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // One result word as text for mismatch reports
    function automatic string line_text(input i2crtm_pkg::result_t r);
        return $sformatf("scl=%b pull=%b busy=%b done=%b miss=%b data=%h",
                         r.scl_level, r.sda_pull_low, r.busy_res, r.done_res,
                         r.ack_missing, r.read_data);
    endfunction

    task automatic enter_stop(input logic err);
        ph     = i2crtm_pkg::PH_STOP_LOW;
        bitcnt = {3'b000, err};
    endtask

    // Advance the bus model by one tick and produce the expected line levels
    task automatic predict_bus_tick(input i2crtm_pkg::item_t w,
                                    output i2crtm_pkg::result_t r);
        logic [2:0] last;
        r.scl_level    = 1'b1;
        r.sda_pull_low = 1'b0;
        r.busy_res     = 1'b1;
        r.done_res     = 1'b0;
        r.ack_missing  = 1'b0;
        case (ph)
            i2crtm_pkg::PH_TX_LOW:
            begin
                r.scl_level    = 1'b0;
                r.sda_pull_low = ~shreg[7];
                ph = i2crtm_pkg::PH_TX_HIGH;
            end
            i2crtm_pkg::PH_TX_HIGH:
            begin
                r.sda_pull_low = ~shreg[7];
                shreg  = shreg << 1;
                bitcnt = bitcnt + 4'd1;
                if (bitcnt >= i2crtm_pkg::BITS_PER_BYTE)
                begin
                    bitcnt = '0;
                    polls  = '0;
                    ph     = i2crtm_pkg::PH_ACK_LOW;
                end
                else
                begin
                    ph = i2crtm_pkg::PH_TX_LOW;
                end
            end
            i2crtm_pkg::PH_ACK_LOW:
            begin
                r.scl_level = 1'b0;
                ph = i2crtm_pkg::PH_ACK_HIGH;
            end
            i2crtm_pkg::PH_ACK_HIGH:
            begin
                if (!w.sda_sample)
                begin
                    byte_idx = byte_idx + 3'd1;
                    last = (h_op == i2crtm_pkg::OP_WRITE) ? i2crtm_pkg::LAST_BYTE_WRITE
                                                          : i2crtm_pkg::LAST_BYTE_OTHER;
                    if (h_op == i2crtm_pkg::OP_READ)
                    begin
                        bitcnt = '0;
                        ph     = i2crtm_pkg::PH_RX_LOW;
                    end
                    else if (byte_idx <= last)
                    begin
                        shreg  = request_byte(byte_idx);
                        bitcnt = '0;
                        ph     = i2crtm_pkg::PH_TX_LOW;
                    end
                    else
                    begin
                        enter_stop(1'b0);
                    end
                end
                else if (polls >= poll_limit)
                begin
                    enter_stop(1'b1);
                end
                else
                begin
                    polls = polls + 8'd1;
                end
            end
            i2crtm_pkg::PH_RX_LOW:
            begin
                r.scl_level = 1'b0;
                ph = i2crtm_pkg::PH_RX_HIGH;
            end
            i2crtm_pkg::PH_RX_HIGH:
            begin
                rx_word = {rx_word[14:0], w.sda_sample};
                bitcnt  = bitcnt + 4'd1;
                if (bitcnt >= i2crtm_pkg::BITS_PER_BYTE)
                begin
                    bitcnt = '0;
                    ph     = i2crtm_pkg::PH_MACK_LOW;
                end
                else
                begin
                    ph = i2crtm_pkg::PH_RX_LOW;
                end
            end
            i2crtm_pkg::PH_MACK_LOW:
            begin
                r.scl_level    = 1'b0;
                r.sda_pull_low = (byte_idx == i2crtm_pkg::FIRST_READ_BYTE);
                ph = i2crtm_pkg::PH_MACK_HIGH;
            end
            i2crtm_pkg::PH_MACK_HIGH:
            begin
                // ACK the first read byte, NACK the last one
                r.sda_pull_low = (byte_idx == i2crtm_pkg::FIRST_READ_BYTE);
                if (byte_idx == i2crtm_pkg::FIRST_READ_BYTE)
                begin
                    byte_idx = i2crtm_pkg::SECOND_READ_BYTE;
                    bitcnt   = '0;
                    ph       = i2crtm_pkg::PH_RX_LOW;
                end
                else
                begin
                    enter_stop(1'b0);
                end
            end
            i2crtm_pkg::PH_STOP_LOW:
            begin
                r.scl_level    = 1'b0;
                r.sda_pull_low = 1'b1;
                ph = i2crtm_pkg::PH_STOP_HIGH;
            end
            i2crtm_pkg::PH_STOP_HIGH:
            begin
                r.sda_pull_low = 1'b1;
                ph = i2crtm_pkg::PH_STOP_END;
            end
            i2crtm_pkg::PH_STOP_END:
            begin
                r.done_res    = 1'b1;
                r.ack_missing = bitcnt[0];
                bitcnt = '0;
                ph     = i2crtm_pkg::PH_IDLE;
            end
            default:
            begin
                // Idle: latch a request and drive START, or just pass the tick
                ph = i2crtm_pkg::PH_IDLE;
                if (w.operation != i2crtm_pkg::OP_TICK)
                begin
                    h_op     = w.operation;
                    h_addr   = w.device_address;
                    h_ptr    = w.register_pointer;
                    h_val    = w.write_value;
                    byte_idx = '0;
                    bitcnt   = '0;
                    polls    = '0;
                    shreg    = request_byte(3'd0);
                    if (w.operation == i2crtm_pkg::OP_READ)
                        rx_word = '0;
                    r.sda_pull_low = 1'b1;
                    ph = i2crtm_pkg::PH_TX_LOW;
                end
                else
                begin
                    r.busy_res = 1'b0;
                end
            end
        endcase
        r.read_data = rx_word;
    endtask

    // ------------------------------------------------------------------
    // Shared state between the sender, the receiver and the checker
    // ------------------------------------------------------------------
    i2crtm_pkg::result_t pending_lines[$];     // expected result words, oldest first
    int      fail_count    = 0;
    int      ticks_sent    = 0;
    int      ticks_checked = 0;
    int      transfers     = 0;
    int      naks_seen     = 0;
    int      limit_writes  = 0;
    int      cycle_count   = 0;
    bit      idle_on       = 1'b1; // random gaps and stalls on both sides
    int      hold_cycles   = 0;    // one-shot long stall for the receiver

    // Watchdog: end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_lines.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: draw a stall length per result word, or take the long hold
    // when one is requested, then wait for the next word to be taken.
    initial
    begin
        int n;
        result_stall = 1'b0;
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                n = idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    // Checker: compare every accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        i2crtm_pkg::result_t got;
        i2crtm_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{scl_level, sda_pull_low, busy_res, done_res, ack_missing, read_data};
            if (pending_lines.size() == 0)
            begin
                fail_count <= fail_count + 1;
                if (fail_count < 10)
                    $display("unexpected result word: %s", line_text(got));
            end
            else
            begin
                want = pending_lines.pop_front();
                ticks_checked <= ticks_checked + 1;
                if (got.done_res && got.ack_missing)
                    naks_seen <= naks_seen + 1;
                if (got.scl_level !== want.scl_level
                    || got.sda_pull_low !== want.sda_pull_low
                    || got.busy_res !== want.busy_res
                    || got.done_res !== want.done_res
                    || got.ack_missing !== want.ack_missing
                    || got.read_data !== want.read_data)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                    begin
                        $display("mismatch on word %0d: expected %s",
                                 ticks_checked, line_text(want));
                        $display("                    actual   %s", line_text(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one tick word after a random gap; predict it once it is taken.
    // Valid stays high when the next word follows with no gap.
    task automatic send_tick(input i2crtm_pkg::item_t w);
        int                  gap;
        i2crtm_pkg::result_t want;
        gap = idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid       <= 1'b1;
        operation        <= w.operation;
        device_address   <= w.device_address;
        register_pointer <= w.register_pointer;
        write_value      <= w.write_value;
        sda_sample       <= w.sda_sample;
        do @(posedge clk); while (item_stall);
        predict_bus_tick(w, want);
        pending_lines.push_back(want);
        ticks_sent++;
    endtask

    // Plain ticks while idle, random content apart from the operation
    task automatic send_idle(input int n);
        i2crtm_pkg::item_t w;
        repeat (n)
        begin
            w = i2crtm_pkg::item_t'(35'({$urandom, $urandom}));
            w.operation = i2crtm_pkg::OP_TICK;
            send_tick(w);
        end
    endtask

    // Pause: drop valid and hold until every expected word is back, then let
    // the pipeline settle.
    task automatic drain;
        item_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_poll_limit(input logic [7:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        poll_limit  = v;
        limit_writes++;
    endtask

    // Run one whole transaction, acting as the slave. The slave ACKs after a
    // random number of high polls up to ack_wait_max, never ACKs byte
    // refuse_at (NONE for a well-behaved slave) and returns slave_data on reads.
    // Request fields on busy ticks are random; the block has to ignore them.
    task automatic run_transfer(input logic [1:0] op, input logic [7:0] addr,
                                input logic [7:0] ptr, input logic [15:0] val,
                                input logic [15:0] slave_data, input int refuse_at,
                                input int ack_wait_max);
        i2crtm_pkg::item_t w;
        int    ack_wait;
        int    pos;
        w.operation        = op;
        w.device_address   = addr;
        w.register_pointer = ptr;
        w.write_value      = val;
        w.sda_sample       = 1'($urandom);
        send_tick(w);
        transfers++;
        ack_wait = 0;
        while (ph != i2crtm_pkg::PH_IDLE)
        begin
            w = i2crtm_pkg::item_t'(35'({$urandom, $urandom}));
            case (ph)
                i2crtm_pkg::PH_ACK_LOW:
                    ack_wait = int'($urandom_range(0, ack_wait_max));
                i2crtm_pkg::PH_ACK_HIGH:
                begin
                    if (int'(byte_idx) == refuse_at)
                        w.sda_sample = 1'b1;
                    else if (ack_wait > 0)
                    begin
                        w.sda_sample = 1'b1;
                        ack_wait--;
                    end
                    else
                        w.sda_sample = 1'b0;
                end
                i2crtm_pkg::PH_RX_HIGH:
                begin
                    pos = (byte_idx == i2crtm_pkg::FIRST_READ_BYTE) ? 15 - int'(bitcnt)
                                                                    : 7 - int'(bitcnt);
                    w.sda_sample = slave_data[pos];
                end
                default: ;
            endcase
            send_tick(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks with no request leave the bus idle
    task automatic test_idle_ticks;
        send_idle(6);
    endtask

    // Every transaction kind with both line levels in every field
    task automatic test_each_operation;
        run_transfer(i2crtm_pkg::OP_WRITE, 8'h00, 8'hFF, 16'hFF00, 16'h0000, NONE, 0);
        run_transfer(i2crtm_pkg::OP_POINT, 8'hA5, 8'h5A, 16'h1234, 16'h0000, NONE, 2);
        run_transfer(i2crtm_pkg::OP_READ,  8'h6E, 8'h3C, 16'hC3C3, 16'hA55A, NONE, 3);
        send_idle(2);
    endtask

    // A slave that stops ACKing at the address, the pointer or the last value
    // byte still gets a STOP; the failed read clears the data left behind.
    task automatic test_missing_ack;
        run_transfer(i2crtm_pkg::OP_WRITE, 8'h90, 8'h01, 16'hBEEF, 16'h0000,
                     int'(i2crtm_pkg::LAST_BYTE_WRITE), 2);
        run_transfer(i2crtm_pkg::OP_POINT, 8'h90, 8'h02, 16'h0000, 16'h0000, 1, 1);
        run_transfer(i2crtm_pkg::OP_READ,  8'h91, 8'h00, 16'h0000, 16'h7FFE, 0, 1);
    endtask

    // Poll limit at both extremes, then back to the reset value; a refusing
    // slave at the top limit runs the poll counter to its end without a wrap.
    task automatic test_poll_limits;
        write_poll_limit(8'd0);
        run_transfer(i2crtm_pkg::OP_POINT, 8'h20, 8'h40, 16'h0000, 16'h0000, NONE, 1);
        run_transfer(i2crtm_pkg::OP_READ,  8'h21, 8'h00, 16'h0000, 16'h1357, 0, 0);
        write_poll_limit(8'd255);
        run_transfer(i2crtm_pkg::OP_POINT, 8'h20, 8'h07, 16'h0000, 16'h0000, 0, 0);
        write_poll_limit(i2crtm_pkg::ACK_POLL_RESET);
        run_transfer(i2crtm_pkg::OP_POINT, 8'h20, 8'h07, 16'h0000, 16'h0000, NONE, 11);
    endtask

    // Long receiver hold while words keep coming, then a full pause
    task automatic test_backpressure;
        idle_on = 1'b0;
        hold_cycles = 300;
        run_transfer(i2crtm_pkg::OP_WRITE, 8'h3A, 8'hC5, 16'h5AA5, 16'h0000, NONE, 1);
        drain();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed transactions with random content; now and then a
    // refusing or slow slave, a new poll limit, or a change of idling.
    task automatic test_random_traffic;
        int          start;
        int          pick;
        int          refuse;
        int          wait_max;
        logic [1:0]  op;
        logic [7:0]  new_limit;
        start = ticks_sent;
        while (ticks_sent - start < RANDOM_TICKS)
        begin
            pick = int'($urandom_range(0, 19));
            if (pick == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       new_limit = 8'd0;
                    1:       new_limit = 8'd1;
                    2:       new_limit = 8'd255;
                    default: new_limit = 8'($urandom_range(2, 12));
                endcase
                write_poll_limit(new_limit);
            end
            else if (pick == 1)
            begin
                idle_on = !idle_on;
            end
            else if (pick == 2)
            begin
                send_idle(int'($urandom_range(1, 4)));
            end
            else
            begin
                op = 2'($urandom_range(1, 3));
                refuse = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 3)) : NONE;
                wait_max = (poll_limit < 4) ? int'(poll_limit) : 4;
                if ($urandom_range(0, 9) == 0)
                    wait_max = int'(poll_limit) + 2;
                run_transfer(op, 8'($urandom), 8'($urandom), 16'($urandom),
                             16'($urandom), refuse, wait_max);
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        item_valid       = 1'b0;
        operation        = i2crtm_pkg::OP_TICK;
        device_address   = '0;
        register_pointer = '0;
        write_value      = '0;
        sda_sample       = 1'b1;
        cfg_valid        = 1'b0;
        cfg_data         = '0;

        // Hold reset, then release it on a rising edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_each_operation();
        test_missing_ack();
        test_poll_limits();
        test_backpressure();
        test_random_traffic();

        // Drop valid, wait for the last words, then let the pipeline settle
        item_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d transactions over %0d bus ticks, %0d ended without ACK",
                 transfers, ticks_sent, naks_seen);
        $display("checked %0d result words across %0d poll limit settings",
                 ticks_checked, limit_writes + 1);
        if (fail_count == 0 && pending_lines.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
